/* sv/pbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants of the protobuf field stream decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 10;
  localparam int GRP_W                = 4;
  localparam int FIELD_W              = 29;
  localparam int VALUE_W              = 64;
  localparam int LEFT_W               = 32;
  localparam int FIXED32_BYTES        = 4;
  localparam int FIXED64_BYTES        = 8;

  typedef enum logic [5:0] {
    PH_KEY     = 6'b000001,
    PH_VARINT  = 6'b000010,
    PH_FIXED32 = 6'b000100,
    PH_FIXED64 = 6'b001000,
    PH_LENGTH  = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_VARINT  = 3'd0,
    KIND_FIXED32 = 3'd1,
    KIND_FIXED64 = 3'd2,
    KIND_LENGTH  = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERLONG = 2'd1,
    ERR_WIRETYPE = 2'd2
  } err_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef struct packed {
    phase_t               phase;
    logic [VALUE_W-1:0]   acc;
    logic [GRP_W-1:0]     count;
    logic [FIELD_W-1:0]   field;
    logic [2:0]           wtype;
    logic [LEFT_W-1:0]    left;
  } state_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [FIELD_W-1:0]   field;
    logic [VALUE_W-1:0]   value;
    err_t                 err;
    logic                 last;
  } result_t;

endpackage

/* sv/pbd_step.sv */
// ----------------------------------------------------------------------------
// pbd_step
// Per-byte decode: next decoder state and optional result for one byte.
// ----------------------------------------------------------------------------
module pbd_step import pbd_pkg::*; #(
  parameter int MaxVarintBytes = MAX_VARINT_BYTES_DEF
) (
  input  state_t      cur,
  input  logic [7:0]  data_byte,
  output state_t      nxt,
  output result_t     res
);

  logic [VALUE_W-1:0] acc_v;
  logic [VALUE_W-1:0] acc_f;
  logic [6:0]         sh_v;
  logic [6:0]         sh_f;
  logic [GRP_W-1:0]   cnt1;
  logic               cont;
  logic               over;
  logic [LEFT_W-1:0]  sat_len;
  logic [LEFT_W-1:0]  left1;
  logic [GRP_W-1:0]   fixed_total;

  always_comb begin
    sh_v    = 7'(7 * cur.count);
    sh_f    = {cur.count, 3'b000};
    acc_v   = cur.acc | ({{(VALUE_W-7){1'b0}}, data_byte[6:0]} << sh_v);
    acc_f   = cur.acc | ({{(VALUE_W-8){1'b0}}, data_byte} << sh_f);
    cnt1    = cur.count + GRP_W'(1);
    cont    = data_byte[7];
    over    = cont && (cnt1 >= GRP_W'(MaxVarintBytes));
    sat_len = (|acc_v[VALUE_W-1:LEFT_W]) ? {LEFT_W{1'b1}} : acc_v[LEFT_W-1:0];
    left1   = cur.left - LEFT_W'(1);
    fixed_total = (cur.phase == PH_FIXED64) ? GRP_W'(FIXED64_BYTES)
                                            : GRP_W'(FIXED32_BYTES);
  end

  always_comb begin
    nxt       = cur;
    res       = '0;
    res.field = cur.field;
    res.kind  = KIND_VARINT;
    res.err   = ERR_NONE;
    unique case (cur.phase)
      PH_KEY: begin
        if (!cont) begin
          nxt.field     = acc_v[FIELD_W+2:3];
          nxt.wtype     = acc_v[2:0];
          nxt.acc       = '0;
          nxt.count     = '0;
          case (acc_v[2:0])
            WT_VARINT:  nxt.phase = PH_VARINT;
            WT_FIXED64: nxt.phase = PH_FIXED64;
            WT_LENGTH:  nxt.phase = PH_LENGTH;
            WT_FIXED32: nxt.phase = PH_FIXED32;
            default: begin
              nxt.phase = PH_KEY;
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.field = acc_v[FIELD_W+2:3];
              res.err   = ERR_WIRETYPE;
              res.last  = 1'b1;
            end
          endcase
        end else if (over) begin
          nxt.acc   = '0;
          nxt.count = '0;
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.field = '0;
          res.err   = ERR_OVERLONG;
          res.last  = 1'b1;
        end else begin
          nxt.acc   = acc_v;
          nxt.count = cnt1;
        end
      end
      PH_VARINT, PH_LENGTH: begin
        if (cont && !over) begin
          nxt.acc   = acc_v;
          nxt.count = cnt1;
        end else begin
          nxt.acc   = '0;
          nxt.count = '0;
          nxt.phase = PH_KEY;
          res.valid = 1'b1;
          res.last  = 1'b1;
          if (over) begin
            res.kind = KIND_ERROR;
            res.err  = ERR_OVERLONG;
          end else if (cur.phase == PH_VARINT) begin
            res.kind  = KIND_VARINT;
            res.value = acc_v;
          end else begin
            res.kind  = KIND_LENGTH;
            res.value = acc_v;
            nxt.left  = sat_len;
            if (sat_len != '0) begin
              res.last  = 1'b0;
              nxt.phase = PH_PAYLOAD;
            end
          end
        end
      end
      PH_FIXED32, PH_FIXED64: begin
        if (cnt1 >= fixed_total) begin
          nxt.acc   = '0;
          nxt.count = '0;
          nxt.phase = PH_KEY;
          res.valid = 1'b1;
          res.kind  = (cur.phase == PH_FIXED64) ? KIND_FIXED64 : KIND_FIXED32;
          res.value = acc_f;
          res.last  = 1'b1;
        end else begin
          nxt.acc   = acc_f;
          nxt.count = cnt1;
        end
      end
      PH_PAYLOAD: begin
        nxt.left  = left1;
        res.valid = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.value = {{(VALUE_W-8){1'b0}}, data_byte};
        res.last  = (left1 == '0);
        if (left1 == '0) begin
          nxt.phase = PH_KEY;
          nxt.acc   = '0;
          nxt.count = '0;
        end
      end
      default: begin
        nxt.phase = PH_KEY;
        nxt.acc   = '0;
        nxt.count = '0;
      end
    endcase
  end

endmodule

/* sv/protobuf_field_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// protobuf_field_stream_decoder_core
// Protobuf wire-format decoder: one encoded byte in, at most one result out.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid/byte_ready, data_byte) carries the encoded
//   message one byte per request. Each key is split into field number and
//   wire type; varint, fixed32, fixed64 and length-delimited values follow.
//   The item channel (item_valid/item_ready) delivers results: one per
//   varint or fixed value, one length header plus one result per payload
//   byte for length-delimited fields, and error results for overlong
//   varints or unsupported wire types, after which decoding restarts at a
//   key. Key bytes and non-final value bytes produce no result.
//   A result's last byte is held in the input register for the decode
//   step, then the result register loads and offers it. Throughput: one
//   byte per cycle while the receiver takes results, set by the single
//   decode step between those two registers.
//   Reset: decoder waits for a key, both registers are empty.
//   When the receiver stalls, the result register holds, the input register
//   fills, and byte_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module protobuf_field_stream_decoder_core import pbd_pkg::*; #(
  parameter int MaxVarintBytes = MAX_VARINT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         data_byte,
  output logic               item_valid,
  input  logic               item_ready,
  output logic [2:0]         item_kind,
  output logic [FIELD_W-1:0] field_number,
  output logic [VALUE_W-1:0] field_value,
  output logic [1:0]         error_code,
  output logic               last_of_field
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  state_t     state;
  state_t     state_next;
  result_t    res;
  result_t    item;
  logic       advance;

  pbd_step #(
    .MaxVarintBytes(MaxVarintBytes)
  ) u_step (
    .cur       (state),
    .data_byte (stage_byte),
    .nxt       (state_next),
    .res       (res)
  );

  assign advance    = stage_valid && (!item_valid || item_ready);
  assign byte_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_ready) begin
      stage_valid <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      stage_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_KEY;
      state.acc       <= '0;
      state.count     <= '0;
      state.field     <= '0;
      state.wtype     <= '0;
      state.left      <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: load on advance, drain when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= res.valid;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
    if (advance && res.valid) begin
      item <= res;
    end
  end

  assign item_kind     = item.kind;
  assign field_number  = item.field;
  assign field_value   = item.value;
  assign error_code    = item.err;
  assign last_of_field = item.last;

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    item_valid && (item_kind == KIND_ERROR) |-> last_of_field)
    else $error("error result without last_of_field");

  a_error_code_match: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> ((item_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error_code does not match item_kind");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_PAYLOAD) |-> (state.left != '0))
    else $error("payload phase with nothing left");

  a_varint_count: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_KEY || state.phase == PH_VARINT || state.phase == PH_LENGTH)
    |-> (state.count < GRP_W'(MaxVarintBytes)))
    else $error("varint group count past limit");

  a_payload_byte: assert property (@(posedge clk) disable iff (rst)
    item_valid && (item_kind == KIND_PAYLOAD) |-> (field_value[VALUE_W-1:8] == '0))
    else $error("payload byte not zero-extended");

endmodule
